@@ design/ltw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltw_pkg
// Types and constants shared by the character display text writer.
// ----------------------------------------------------------------------------
package ltw_pkg;

    localparam logic [5:0] MAX_COLUMNS = 6'd40;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CHAR_CR   = 8'd13;
    localparam logic [7:0] CHAR_LF   = 8'd10;
    localparam logic [7:0] CHAR_NUL  = 8'd0;

    localparam logic [1:0] MODE_CHAR  = 2'd0;
    localparam logic [1:0] MODE_MOVE  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] CFG_ROWS    = 3'd0;
    localparam logic [2:0] CFG_COLUMNS = 3'd1;
    localparam logic [2:0] CFG_LINE0   = 3'd2;
    localparam logic [2:0] CFG_LINE1   = 3'd3;
    localparam logic [2:0] CFG_LINE2   = 3'd4;
    localparam logic [2:0] CFG_LINE3   = 3'd5;

    typedef struct packed {
        logic [2:0]      rows;
        logic [5:0]      columns;
        logic [3:0][7:0] line_cmd;
    } cfg_t;

    typedef struct packed {
        logic [1:0] line_index;
        logic [5:0] column_pointer;
        logic [7:0] written_count;
    } cursor_t;

    // Up to three bytes per item, each sent as two nibbles.
    typedef struct packed {
        logic            refused;
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic [2:0]      rs;
    } job_t;

endpackage

@@ design/ltw_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltw_step
// Works out the bytes to send for one item and the cursor state it leaves.
// ----------------------------------------------------------------------------
module ltw_step
    import ltw_pkg::*;
(
    input  cfg_t       cfg,
    input  cursor_t    cur,
    input  logic [1:0] mode,
    input  logic [7:0] char_code,
    input  logic       string_start,
    input  logic [1:0] row,
    input  logic [5:0] column,
    output cursor_t    cur_next,
    output job_t       job
);

    logic [5:0] cols;
    logic [8:0] screen_size;
    logic [8:0] total;
    logic       brk;

    assign cols        = (cfg.columns > MAX_COLUMNS) ? MAX_COLUMNS : cfg.columns;
    assign screen_size = 9'(cols) * 9'(cfg.rows);
    assign total       = 9'(row) * 9'(cols) + 9'(column);
    assign brk         = (char_code == CHAR_CR) || (char_code == CHAR_LF);

    always_comb begin
        cursor_t    c;
        job_t       j;
        logic [1:0] li_new;
        c      = cur;
        j      = '0;
        li_new = '0;
        unique case (mode)
            MODE_CHAR: begin
                if (string_start && (9'(cur.written_count) >= screen_size)) begin
                    j.bytes[j.count] = CMD_CLEAR;
                    j.rs[j.count]    = 1'b0;
                    j.count          = j.count + 2'd1;
                    c                = '0;
                end
                if (char_code != CHAR_NUL) begin
                    if (brk || (c.column_pointer >= cols)) begin
                        li_new           = c.line_index + 2'd1;
                        c.column_pointer = '0;
                        c.line_index     = li_new;
                        j.bytes[j.count] = cfg.line_cmd[li_new];
                        j.rs[j.count]    = 1'b0;
                        j.count          = j.count + 2'd1;
                    end
                    if (!brk) begin
                        j.bytes[j.count] = char_code;
                        j.rs[j.count]    = 1'b1;
                        j.count          = j.count + 2'd1;
                        c.column_pointer = c.column_pointer + 6'd1;
                        if (c.written_count != 8'hFF) begin
                            c.written_count = c.written_count + 8'd1;
                        end
                    end
                end
            end
            MODE_MOVE: begin
                if ((3'(row) >= cfg.rows) || (column >= cols)) begin
                    j.refused = 1'b1;
                end else begin
                    c.line_index     = row;
                    c.column_pointer = column;
                    c.written_count  = (total > 9'd255) ? 8'hFF : total[7:0];
                    j.bytes[0]       = cfg.line_cmd[row] + {2'b00, column};
                    j.rs[0]          = 1'b0;
                    j.count          = 2'd1;
                end
            end
            MODE_CLEAR: begin
                j.bytes[0] = CMD_CLEAR;
                j.rs[0]    = 1'b0;
                j.count    = 2'd1;
                c          = '0;
            end
            default: begin
            end
        endcase
        cur_next = c;
        job      = j;
    end

endmodule

@@ design/ltw_serializer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltw_serializer
// Holds one item's bytes and hands them out one nibble per transfer.
// ----------------------------------------------------------------------------
module ltw_serializer
    import ltw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  job_t       job_in,
    output logic       load_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [3:0] m_nibble,
    output logic       m_register_select,
    output logic       m_last
);

    job_t       job_reg;
    logic       valid_reg;
    logic [2:0] pos_reg;
    logic [7:0] cur_byte;
    logic       done;
    logic       empty_job;

    assign cur_byte  = job_reg.bytes[pos_reg[2:1]];
    assign empty_job = (job_in.count == 2'd0) && !job_in.refused;

    assign m_valid           = valid_reg;
    assign m_kind            = job_reg.refused;
    assign m_nibble          = job_reg.refused ? 4'h0
                             : (pos_reg[0] ? cur_byte[3:0] : cur_byte[7:4]);
    assign m_register_select = !job_reg.refused && job_reg.rs[pos_reg[2:1]];
    assign m_last            = job_reg.refused || (pos_reg == {job_reg.count, 1'b0} - 3'd1);

    assign done       = valid_reg && m_ready && m_last;
    assign load_ready = !valid_reg || done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (load && !empty_job) begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
        end else if (done) begin
            valid_reg <= 1'b0;
        end else if (valid_reg && m_ready) begin
            pos_reg <= pos_reg + 3'd1;
        end
    end

    // Payload only: loaded with each new item.
    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job_in;
        end
    end

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !job_reg.refused |-> pos_reg < {job_reg.count, 1'b0})
        else $error("nibble position beyond the held bytes");

    a_refused_single: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && job_reg.refused |-> pos_reg == 3'd0)
        else $error("refusal result advanced past its only transfer");

    a_job_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (job_reg.count != 2'd0) || job_reg.refused)
        else $error("empty item held for output");

    a_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && m_ready && !m_last |=> valid_reg && (pos_reg == $past(pos_reg) + 3'd1))
        else $error("item dropped before its last nibble");

endmodule

@@ design/char_lcd_text_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_text_writer
// Text writer for a character display on a 4-bit bus.
// ----------------------------------------------------------------------------
// Items enter on the s_ channel (valid/ready): write a character, move the
// cursor or clear the display. Each item yields zero to six results on the
// m_ channel: nibble strobes, high nibble first, with register select 0 for
// commands and 1 for characters, or a single refusal for an out-of-range
// cursor move. m_last marks an item's final result.
// The cursor state is updated on the input transfer; the first result is
// offered in the next cycle. The nibble serialiser gives one result per
// cycle while m_ready is high, and the next item is taken in the cycle that
// the previous item's last result transfers. Items that cause no result are
// accepted without occupying the output. When the receiver holds m_ready
// low, the current result is held and s_ready falls until the last result
// of the held item has transferred. Reset (aresetn low, synchronous) empties
// the output, homes the cursor, zeroes the character count and loads the
// default register values. Registers are to be written by the user through
// cfg_wr_en / cfg_index / cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module char_lcd_text_writer
    import ltw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_char_code,
    input  logic       s_string_start,
    input  logic [1:0] s_row,
    input  logic [5:0] s_column,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [3:0] m_nibble,
    output logic       m_register_select,
    output logic       m_last
);

    cfg_t    cfg_reg;
    cursor_t cur_reg;
    cursor_t cur_next;
    job_t    job;
    logic    load_ready;
    logic    accept;

    assign s_ready = load_ready;
    assign accept  = s_valid && load_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rows        <= 3'd2;
            cfg_reg.columns     <= 6'd16;
            cfg_reg.line_cmd[0] <= 8'd128;
            cfg_reg.line_cmd[1] <= 8'd192;
            cfg_reg.line_cmd[2] <= 8'd148;
            cfg_reg.line_cmd[3] <= 8'd212;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROWS:    cfg_reg.rows        <= cfg_wdata[2:0];
                CFG_COLUMNS: cfg_reg.columns     <= cfg_wdata[5:0];
                CFG_LINE0:   cfg_reg.line_cmd[0] <= cfg_wdata;
                CFG_LINE1:   cfg_reg.line_cmd[1] <= cfg_wdata;
                CFG_LINE2:   cfg_reg.line_cmd[2] <= cfg_wdata;
                CFG_LINE3:   cfg_reg.line_cmd[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else if (accept) begin
            cur_reg <= cur_next;
        end
    end

    ltw_step u_step (
        .cfg          (cfg_reg),
        .cur          (cur_reg),
        .mode         (s_mode),
        .char_code    (s_char_code),
        .string_start (s_string_start),
        .row          (s_row),
        .column       (s_column),
        .cur_next     (cur_next),
        .job          (job)
    );

    ltw_serializer u_serializer (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (accept),
        .job_in            (job),
        .load_ready        (load_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_nibble          (m_nibble),
        .m_register_select (m_register_select),
        .m_last            (m_last)
    );

endmodule

@@ tb/char_lcd_text_writer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_text_writer_tb
// Self-checking testbench for the character display text writer.
// ----------------------------------------------------------------------------
// Items are sent to the block over the s_ channel. A behavioural model of
// the cursor, line index and character count computes, for each transfer,
// the nibble strobes or refusal that the block should produce. Results on
// the m_ channel are compared field by field with the queued predictions.
// Both sides idle at random for most of the run. The display geometry and
// the line address commands are reprogrammed between phases, extremes
// included, and one phase drives the character count into saturation.
// ----------------------------------------------------------------------------
module char_lcd_text_writer_tb;
    import ltw_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic       kind;
        logic [3:0] nibble;
        logic       register_select;
        logic       last;
    } strobe_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [2:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_mode;
    logic [7:0] s_char_code;
    logic       s_string_start;
    logic [1:0] s_row;
    logic [5:0] s_column;
    logic       m_valid;
    logic       m_ready;
    logic       m_kind;
    logic [3:0] m_nibble;
    logic       m_register_select;
    logic       m_last;

    // Model of the display writer: configuration and cursor state.
    logic [2:0] cfg_rows = 3'd2;
    logic [5:0] cfg_cols = 6'd16;
    logic [7:0] cfg_line_cmd [4] = '{8'd128, 8'd192, 8'd148, 8'd212};
    logic [1:0] cur_line = '0;
    logic [5:0] cur_col = '0;
    logic [7:0] char_count = '0;

    strobe_t strobe_q [$];
    int      mismatch_count = 0;
    int      quiet_cycles = 0;
    bit      idle_on = 1'b1;

    char_lcd_text_writer dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_char_code       (s_char_code),
        .s_string_start    (s_string_start),
        .s_row             (s_row),
        .s_column          (s_column),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_nibble          (m_nibble),
        .m_register_select (m_register_select),
        .m_last            (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int visible_columns();
        return (cfg_cols > MAX_COLUMNS) ? int'(MAX_COLUMNS) : int'(cfg_cols);
    endfunction

    function automatic void push_strobe(logic kind, logic [3:0] nib, logic rs);
        strobe_t s;
        s.kind = kind;
        s.nibble = nib;
        s.register_select = rs;
        s.last = 1'b0;
        strobe_q.push_back(s);
    endfunction

    function automatic void push_byte(logic [7:0] b, logic rs);
        push_strobe(1'b0, b[7:4], rs);
        push_strobe(1'b0, b[3:0], rs);
    endfunction

    function automatic void clear_display();
        push_byte(CMD_CLEAR, 1'b0);
        cur_line = '0;
        cur_col = '0;
        char_count = '0;
    endfunction

    function automatic void predict_strobes(logic [1:0] mode, logic [7:0] ch, logic start,
                                            logic [1:0] row, logic [5:0] col);
        int         cols;
        int         before_n;
        int         total;
        logic       line_break;
        logic [7:0] addr;
        cols = visible_columns();
        before_n = strobe_q.size();
        case (mode)
            MODE_CHAR: begin
                if (start && int'(char_count) >= cols * int'(cfg_rows))
                    clear_display();
                if (ch != CHAR_NUL) begin
                    line_break = (ch == CHAR_CR) || (ch == CHAR_LF);
                    if (line_break || int'(cur_col) >= cols) begin
                        cur_col = '0;
                        cur_line = cur_line + 2'd1;
                        push_byte(cfg_line_cmd[cur_line], 1'b0);
                    end
                    if (!line_break) begin
                        push_byte(ch, 1'b1);
                        cur_col = cur_col + 6'd1;
                        if (char_count != 8'd255)
                            char_count = char_count + 8'd1;
                    end
                end
            end
            MODE_MOVE: begin
                if (int'(row) >= int'(cfg_rows) || int'(col) >= cols) begin
                    push_strobe(1'b1, 4'd0, 1'b0);
                end else begin
                    total = int'(row) * cols + int'(col);
                    cur_line = row;
                    cur_col = col;
                    char_count = (total > 255) ? 8'd255 : 8'(total);
                    addr = cfg_line_cmd[row] + 8'(col);
                    push_byte(addr, 1'b0);
                end
            end
            MODE_CLEAR: clear_display();
            default: ;
        endcase
        if (strobe_q.size() > before_n)
            strobe_q[strobe_q.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: checks results, tracks register writes, predicts transfers
    // ------------------------------------------------------------------
    function automatic void note_mismatch(string what, strobe_t want, strobe_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, what);
            $display("    expected kind=%0d nibble=%h rs=%0d last=%0d",
                     want.kind, want.nibble, want.register_select, want.last);
            $display("    got      kind=%0d nibble=%h rs=%0d last=%0d",
                     got.kind, got.nibble, got.register_select, got.last);
        end
    endfunction

    always @(posedge aclk) begin
        strobe_t got;
        strobe_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_nibble, m_register_select, m_last};
                if (strobe_q.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = strobe_q.pop_front();
                    if (got !== want)
                        note_mismatch("result mismatch", want, got);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROWS:    cfg_rows = cfg_wdata[2:0];
                    CFG_COLUMNS: cfg_cols = cfg_wdata[5:0];
                    CFG_LINE0:   cfg_line_cmd[0] = cfg_wdata;
                    CFG_LINE1:   cfg_line_cmd[1] = cfg_wdata;
                    CFG_LINE2:   cfg_line_cmd[2] = cfg_wdata;
                    CFG_LINE3:   cfg_line_cmd[3] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_strobes(s_mode, s_char_code, s_string_start, s_row, s_column);
        end
    end

    // A stuck handshake ends the run.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver back-pressure in short random bursts.
    always begin
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        m_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver tasks; all are entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] mode, input logic [7:0] ch, input logic start,
                             input logic [1:0] row, input logic [5:0] col);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_char_code <= ch;
        s_string_start <= start;
        s_row <= row;
        s_column <= col;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Lowers valid, waits for every predicted result, then lets any
    // result-free item still in flight pass through.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (strobe_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [2:0] rows, input logic [5:0] cols,
                              input logic [7:0] l0, input logic [7:0] l1,
                              input logic [7:0] l2, input logic [7:0] l3);
        logic [7:0] values [6];
        values = '{8'(rows), 8'(cols), l0, l1, l2, l3};
        for (int i = 0; i < 6; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= values[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly strings of printable characters with the odd line break,
    // in-range cursor moves and clears; the rest is noise.
    task automatic send_random_item();
        logic [1:0] mode;
        logic [7:0] ch;
        logic       start;
        logic [1:0] row;
        logic [5:0] col;
        int         pick;
        int         sel;
        int         lines;
        pick = $urandom_range(0, 99);
        ch = 8'($urandom);
        start = ($urandom_range(0, 5) == 0);
        row = 2'($urandom);
        col = 6'($urandom);
        lines = (cfg_rows > 3'd4) ? 4 : int'(cfg_rows);
        if (pick < 62) begin
            mode = MODE_CHAR;
            sel = $urandom_range(0, 19);
            if (sel < 2)
                ch = sel ? CHAR_CR : CHAR_LF;
            else if (sel == 2)
                ch = CHAR_NUL;
            else if (sel > 5)
                ch = 8'($urandom_range(8'h20, 8'h7e));
        end else if (pick < 82) begin
            mode = MODE_MOVE;
            if ($urandom_range(0, 3) != 0 && lines > 0 && visible_columns() > 0) begin
                row = 2'($urandom_range(0, lines - 1));
                col = 6'($urandom_range(0, visible_columns() - 1));
            end
        end else if (pick < 93) begin
            mode = MODE_CLEAR;
        end else begin
            mode = MODE_UNUSED;
        end
        send_item(mode, ch, start, row, col);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_default_geometry();
        send_item(MODE_CLEAR, 8'h00, 1'b0, 2'd0, 6'd0);
        send_item(MODE_MOVE, 8'h00, 1'b0, 2'd3, 6'd0);
        send_item(MODE_MOVE, 8'h00, 1'b0, 2'd0, 6'd63);
        send_item(MODE_MOVE, 8'h00, 1'b0, 2'd2, 6'd5);
        send_item(MODE_MOVE, 8'h00, 1'b0, 2'd1, 6'd15);
        send_item(MODE_CHAR, 8'h5a, 1'b0, 2'd0, 6'd0);
        // Past the last column: next line's address, then the character.
        send_item(MODE_CHAR, 8'hff, 1'b0, 2'd0, 6'd0);
        // Screen full at a string start: clear comes first.
        send_item(MODE_CHAR, 8'h61, 1'b1, 2'd0, 6'd0);
        send_item(MODE_CHAR, CHAR_CR, 1'b0, 2'd0, 6'd0);
        send_item(MODE_CHAR, CHAR_LF, 1'b0, 2'd0, 6'd0);
        send_item(MODE_CHAR, CHAR_LF, 1'b0, 2'd0, 6'd0);
        send_item(MODE_CHAR, CHAR_LF, 1'b0, 2'd0, 6'd0);
        send_item(MODE_CHAR, CHAR_NUL, 1'b0, 2'd3, 6'd63);
        send_item(MODE_CHAR, 8'h80, 1'b0, 2'd0, 6'd0);
        send_item(MODE_CHAR, 8'h01, 1'b0, 2'd0, 6'd0);
        send_item(MODE_MOVE, 8'hff, 1'b1, 2'd0, 6'd0);
        send_item(MODE_UNUSED, 8'hff, 1'b1, 2'd3, 6'd63);
        // A null byte at a full-screen string start only clears.
        send_item(MODE_MOVE, 8'h00, 1'b0, 2'd1, 6'd15);
        send_item(MODE_CHAR, 8'h78, 1'b0, 2'd0, 6'd0);
        send_item(MODE_CHAR, CHAR_NUL, 1'b1, 2'd0, 6'd0);
        send_item(MODE_CHAR, 8'h7f, 1'b1, 2'd0, 6'd0);
        wait_drained();
    endtask

    task automatic run_phase(input logic [2:0] rows, input logic [5:0] cols,
                             input logic [7:0] l0, input logic [7:0] l1,
                             input logic [7:0] l2, input logic [7:0] l3, input int n);
        set_config(rows, cols, l0, l1, l2, l3);
        repeat (n) send_random_item();
        wait_drained();
    endtask

    task automatic test_geometry_extremes();
        run_phase(3'd1, 6'd1, 8'h00, 8'hff, 8'h01, 8'hfe, 6);
        run_phase(3'd4, 6'd40, 8'hff, 8'h00, 8'($urandom), 8'($urandom), 6);
        // No rows and no columns: every start clears, every character wraps.
        run_phase(3'd0, 6'd0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 6);
        run_phase(3'd7, 6'd63, 8'($urandom), 8'($urandom), 8'hff, 8'h00, 6);
        run_phase(3'd3, 6'd8, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 6);
    endtask

    // Seven lines of forty cannot fill within 255 characters, so the count
    // saturates; a smaller screen then shows whether it held at 255.
    task automatic test_count_saturation();
        set_config(3'd7, 6'd63, 8'd128, 8'd192, 8'd148, 8'd212);
        send_item(MODE_CLEAR, 8'h00, 1'b0, 2'd0, 6'd0);
        send_item(MODE_MOVE, 8'h00, 1'b0, 2'd3, 6'd39);
        repeat (97) send_item(MODE_CHAR, 8'($urandom_range(8'h20, 8'h7e)), 1'b0,
                              2'($urandom), 6'($urandom));
        wait_drained();
        set_config(3'd6, 6'd40, 8'd128, 8'd192, 8'd148, 8'd212);
        send_item(MODE_CHAR, 8'h53, 1'b1, 2'd0, 6'd0);
        wait_drained();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        run_phase(3'd2, 6'd16, 8'd128, 8'd192, 8'd148, 8'd212, 12);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_mode = MODE_CHAR;
        s_char_code = '0;
        s_string_start = 1'b0;
        s_row = '0;
        s_column = '0;
        m_ready = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_geometry();
        test_geometry_extremes();
        test_count_saturation();
        test_back_to_back();

        if (mismatch_count == 0 && strobe_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/ltw_pkg.sv
design/ltw_step.sv
design/ltw_serializer.sv
design/char_lcd_text_writer.sv
tb/char_lcd_text_writer_tb.sv
